// File: sv/crc8_checked_word_deframer_assert.svh
// Assertion macros for the CRC-8 word deframer.
// Used by files that check their own logic; needs clk and rst in scope.
`ifndef CRC8_CHECKED_WORD_DEFRAMER_ASSERT_SVH
`define CRC8_CHECKED_WORD_DEFRAMER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define CWD_ASSERT_IMPLY(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define CWD_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

// File: sv/cwd_pkg.sv
// Shared types, codes and functions of the CRC-8 word deframer.
// No dependencies; imported by every module of the block.
package cwd_pkg;

  localparam logic [1:0] CFG_POLYNOMIAL = 2'd0;
  localparam logic [1:0] CFG_INITIAL    = 2'd1;
  localparam logic [1:0] CFG_WORDS      = 2'd2;

  localparam logic [7:0] POLY_RESET  = 8'h31;
  localparam logic [7:0] INIT_RESET  = 8'hFF;
  localparam logic [3:0] WORDS_RESET = 4'd3;
  localparam logic [3:0] WORDS_MAX   = 4'd8;

  // Position of the next byte in its triplet; the fourth code acts as PH_HIGH.
  localparam logic [1:0] PH_HIGH = 2'd0;
  localparam logic [1:0] PH_LOW  = 2'd1;
  localparam logic [1:0] PH_CRC  = 2'd2;

  typedef struct packed {
    logic [7:0] polynomial;
    logic [7:0] initial_value;
    logic [3:0] frame_len;
  } cwd_cfg_t;

  typedef struct packed {
    logic [15:0] word_value;
    logic        word_ok;
    logic        frame_ok;
    logic [2:0]  word_index;
    logic        last_word;
  } cwd_result_t;

  // MSB-first CRC-8 over one byte, no reflection.
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in,
                                           input logic [7:0] b,
                                           input logic [7:0] poly);
    logic [7:0] c;
    c = crc_in ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ((c << 1) ^ poly) : (c << 1);
    end
    return c;
  endfunction

  // Zero acts as one word, anything above the maximum as the maximum.
  function automatic logic [3:0] frame_words(input logic [3:0] w);
    logic [3:0] n;
    if (w == 4'd0) begin
      n = 4'd1;
    end else if (w > WORDS_MAX) begin
      n = WORDS_MAX;
    end else begin
      n = w;
    end
    return n;
  endfunction

endpackage

// File: sv/cwd_cfg_regs.sv
// Configuration registers of the CRC-8 word deframer.
// Depends on cwd_pkg for register codes, reset values and the config struct.
module cwd_cfg_regs (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [1:0]        cfg_index,
  input  logic [7:0]        cfg_data,
  output cwd_pkg::cwd_cfg_t cfg
);
  import cwd_pkg::*;

  logic [7:0] polynomial;
  logic [7:0] initial_value;
  logic [3:0] words_per_frame;

  always_ff @(posedge clk) begin
    if (rst) begin
      polynomial      <= POLY_RESET;
      initial_value   <= INIT_RESET;
      words_per_frame <= WORDS_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_POLYNOMIAL: polynomial      <= cfg_data;
        CFG_INITIAL:    initial_value   <= cfg_data;
        CFG_WORDS:      words_per_frame <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  assign cfg.polynomial    = polynomial;
  assign cfg.initial_value = initial_value;
  assign cfg.frame_len     = frame_words(words_per_frame);

endmodule

// File: sv/cwd_assembler.sv
// Input register, triplet tracking, CRC and frame bookkeeping.
// Depends on cwd_pkg for the CRC function, phase codes and structs.
module cwd_assembler (
  input  logic                 clk,
  input  logic                 rst,
  input  cwd_pkg::cwd_cfg_t    cfg,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           data_byte,
  input  logic                 frame_start,
  input  logic                 out_free,
  output logic                 res_valid,
  output cwd_pkg::cwd_result_t res
);
  import cwd_pkg::*;

  logic       in_vld_q;
  logic [7:0] byte_q;
  logic       start_q;

  logic [1:0] byte_phase, byte_phase_next;
  logic [7:0] running_crc, running_crc_next;
  logic [7:0] high_part, high_part_next;
  logic [7:0] low_part, low_part_next;
  logic [2:0] word_counter, word_counter_next;
  logic       frame_good, frame_good_next;

  logic       take;
  logic [1:0] ph;
  logic [2:0] cnt;
  logic       good;
  logic       ok;
  logic       last;

  assign take     = in_vld_q && out_free;
  assign in_stall = in_vld_q && !out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld_q <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_vld_q <= 1'b1;
    end else if (take) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      byte_q  <= data_byte;
      start_q <= frame_start;
    end
  end

  // A frame start drops any partial word and restarts the frame.
  assign ph   = start_q ? PH_HIGH : byte_phase;
  assign cnt  = start_q ? 3'd0 : word_counter;
  assign good = start_q ? 1'b1 : frame_good;
  assign ok   = (byte_q == running_crc);
  assign last = 4'({1'b0, cnt} + 4'd1) >= cfg.frame_len;

  always_comb begin
    byte_phase_next   = ph;
    running_crc_next  = running_crc;
    high_part_next    = high_part;
    low_part_next     = low_part;
    word_counter_next = cnt;
    frame_good_next   = good;
    res_valid         = 1'b0;
    case (ph)
      PH_LOW: begin
        low_part_next    = byte_q;
        running_crc_next = crc8_byte(running_crc, byte_q, cfg.polynomial);
        byte_phase_next  = PH_CRC;
      end
      PH_CRC: begin
        res_valid        = take;
        byte_phase_next  = PH_HIGH;
        running_crc_next = cfg.initial_value;
        if (last) begin
          word_counter_next = 3'd0;
          frame_good_next   = 1'b1;
        end else begin
          word_counter_next = cnt + 3'd1;
          frame_good_next   = good & ok;
        end
      end
      default: begin
        high_part_next   = byte_q;
        running_crc_next = crc8_byte(cfg.initial_value, byte_q, cfg.polynomial);
        byte_phase_next  = PH_LOW;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_phase   <= PH_HIGH;
      running_crc  <= INIT_RESET;
      word_counter <= 3'd0;
      frame_good   <= 1'b1;
    end else if (take) begin
      byte_phase   <= byte_phase_next;
      running_crc  <= running_crc_next;
      word_counter <= word_counter_next;
      frame_good   <= frame_good_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      high_part <= high_part_next;
      low_part  <= low_part_next;
    end
  end

  assign res.word_value = {high_part, low_part};
  assign res.word_ok    = ok;
  assign res.frame_ok   = good & ok;
  assign res.word_index = cnt;
  assign res.last_word  = last;

endmodule

// File: sv/cwd_out_reg.sv
// Result register of the CRC-8 word deframer; holds a word while stalled.
// Depends on cwd_pkg for the result struct.
module cwd_out_reg (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 res_valid,
  input  cwd_pkg::cwd_result_t res,
  output logic                 out_free,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [15:0]          word_value,
  output logic                 word_ok,
  output logic                 frame_ok,
  output logic [2:0]           word_index,
  output logic                 last_word
);
  import cwd_pkg::*;

  cwd_result_t held;

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && res_valid) begin
      held <= res;
    end
  end

  assign word_value = held.word_value;
  assign word_ok    = held.word_ok;
  assign frame_ok   = held.frame_ok;
  assign word_index = held.word_index;
  assign last_word  = held.last_word;

endmodule

// File: sv/crc8_checked_word_deframer.sv
// CRC-8 checked word deframer: splits a byte stream into CRC-protected words.
// Takes one byte per item on the input channel (data_byte, frame_start) and
// gives one item per word on the output channel: word_value, word_ok,
// frame_ok, word_index and last_word. Bytes come as high, low, CRC triplets;
// frame_start marks the high byte of word 0 and drops any partial word.
// Throughput: one byte per cycle while out_stall holds no word; the CRC step
// of a byte is eight unrolled shift-and-XOR steps between the input register
// and the state. The CRC byte of a word passes through the input register,
// then the finished word is loaded into the result register and out_valid
// rises. While out_stall holds a word, in_stall rises once the input
// register holds a byte (an empty one first takes one more byte); the block
// never drops or repeats a word.
// Configuration (polynomial, initial value, words per frame) is written
// through cfg_write/cfg_index/cfg_data (an index beyond the list is ignored);
// the user must write it only while the block is idle; the block does not enforce this.
// Reset (rst, synchronous) empties both registers, restores the default
// configuration and starts at the high byte of word 0 of a new frame.
// Depends on cwd_pkg, cwd_cfg_regs, cwd_assembler, cwd_out_reg.
module crc8_checked_word_deframer (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        frame_start,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] word_value,
  output logic        word_ok,
  output logic        frame_ok,
  output logic [2:0]  word_index,
  output logic        last_word
);
  import cwd_pkg::*;

  `include "crc8_checked_word_deframer_assert.svh"

  cwd_cfg_t    cfg;
  cwd_result_t res;
  logic        res_valid;
  logic        out_free;

  cwd_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  cwd_assembler u_asm (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .data_byte   (data_byte),
    .frame_start (frame_start),
    .out_free    (out_free),
    .res_valid   (res_valid),
    .res         (res)
  );

  cwd_out_reg u_out (
    .clk        (clk),
    .rst        (rst),
    .res_valid  (res_valid),
    .res        (res),
    .out_free   (out_free),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .word_value (word_value),
    .word_ok    (word_ok),
    .frame_ok   (frame_ok),
    .word_index (word_index),
    .last_word  (last_word)
  );

  `CWD_ASSERT_NEXT(a_stall_hold, out_valid && out_stall, out_valid && $stable(word_value), "held word changed under stall")
  `CWD_ASSERT_IMPLY(a_last_mark, out_valid, last_word == (4'({1'b0, word_index} + 4'd1) >= cfg.frame_len), "last-word mark disagrees with index")
  `CWD_ASSERT_IMPLY(a_frame_needs_word, out_valid && frame_ok, word_ok, "frame good on a bad word")
  `CWD_ASSERT_IMPLY(a_stall_cause, in_stall, out_valid && out_stall, "input stalled without a held word")
  `CWD_ASSERT_NEXT(a_result_loaded, res_valid && out_free, out_valid && word_value == $past(res.word_value), "finished word not loaded")

endmodule

// File: verif/tb_crc8_checked_word_deframer.sv
// Testbench for crc8_checked_word_deframer: feeds byte triplets with random gaps
// and output stalls, predicts every word and compares it field by field.
// Depends on cwd_pkg and the block's RTL.
module tb_crc8_checked_word_deframer;
  timeunit 1ns;
  timeprecision 1ps;
  import cwd_pkg::*;

  localparam logic [1:0] CFG_SPARE = 2'd3;  // beyond the register list, ignored
  localparam int SETTLE_CYCLES = 6;
  localparam int TOTAL_ITEMS = 550;

  typedef enum logic [1:0] {ROW_BYTE, ROW_WORD, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic [7:0]  value;
    logic        start;
    logic [1:0]  reg_index;
    cwd_result_t want;
  } plan_row_t;

  typedef struct packed {
    logic [1:0] phase;
    logic [7:0] crc;
    logic [7:0] hi;
    logic [7:0] lo;
    logic [2:0] word_no;
    logic       good;
  } deframe_state_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_index = CFG_POLYNOMIAL;
  logic [7:0]  cfg_data = 8'h00;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = 8'h00;
  logic        frame_start = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] word_value;
  logic        word_ok;
  logic        frame_ok;
  logic [2:0]  word_index;
  logic        last_word;

  cwd_cfg_t       regs_model;
  deframe_state_t rx;
  cwd_result_t    pending_words[$];
  int             fails = 0;
  int             sent = 0;
  int             stall_left = 0;
  bit             calm = 1'b0;

  crc8_checked_word_deframer dut (.*);

  always #5 clk = ~clk;

  // MSB-first CRC-8, one input bit per step.
  function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] b,
                                           input logic [7:0] poly);
    logic [7:0] c;
    logic       fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[7] ^ b[i];
      c = {c[6:0], 1'b0} ^ (fb ? poly : 8'h00);
    end
    return c;
  endfunction

  function automatic logic [3:0] frame_len_used(input logic [3:0] w);
    if (w == 4'd0) begin
      return 4'd1;
    end
    return (w > 4'd8) ? 4'd8 : w;
  endfunction

  function automatic void reset_model();
    regs_model = '{POLY_RESET, INIT_RESET, WORDS_RESET};
    rx = '{PH_HIGH, INIT_RESET, 8'h00, 8'h00, 3'd0, 1'b1};
  endfunction

  // Advance the deframer state by one byte; return 1 when a word completes.
  function automatic bit absorb_byte(input logic [7:0] b, input logic s,
                                     output cwd_result_t r);
    logic ok;
    logic last;
    r = '0;
    if (s) begin
      rx.phase = PH_HIGH;
      rx.word_no = 3'd0;
      rx.good = 1'b1;
    end
    if (rx.phase == PH_LOW) begin
      rx.lo = b;
      rx.crc = crc8_feed(rx.crc, b, regs_model.polynomial);
      rx.phase = PH_CRC;
      return 1'b0;
    end
    if (rx.phase != PH_CRC) begin
      rx.hi = b;
      rx.crc = crc8_feed(regs_model.initial_value, b, regs_model.polynomial);
      rx.phase = PH_LOW;
      return 1'b0;
    end
    ok = (b == rx.crc);
    rx.good &= ok;
    last = ({1'b0, rx.word_no} + 4'd1 >= frame_len_used(regs_model.frame_len));
    r = '{{rx.hi, rx.lo}, ok, rx.good, rx.word_no, last};
    rx.phase = PH_HIGH;
    rx.crc = regs_model.initial_value;
    if (last) begin
      rx.word_no = 3'd0;
      rx.good = 1'b1;
    end else begin
      rx.word_no = rx.word_no + 3'd1;
    end
    return 1'b1;
  endfunction

  function automatic plan_row_t row_byte(input logic [7:0] b, input logic s);
    plan_row_t p;
    p = '{ROW_BYTE, b, s, CFG_POLYNOMIAL, '0};
    return p;
  endfunction

  function automatic plan_row_t row_word(input logic [7:0] b, input logic s,
                                         input logic [15:0] w, input logic ok,
                                         input logic fok, input logic [2:0] idx,
                                         input logic last);
    plan_row_t p;
    p = '{ROW_WORD, b, s, CFG_POLYNOMIAL, '{w, ok, fok, idx, last}};
    return p;
  endfunction

  function automatic plan_row_t row_cfg(input logic [1:0] idx, input logic [7:0] val);
    plan_row_t p;
    p = '{ROW_CFG, val, 1'b0, idx, '0};
    return p;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) begin
      return 0;
    end
    return (r < 90) ? $urandom_range(1, 3) : $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] rand_byte();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      return 8'h00;
    end
    return (r == 1) ? 8'hFF : 8'($urandom);
  endfunction

  // Write one register once the block has drained.
  task automatic put_reg(input logic [1:0] idx, input logic [7:0] val);
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      CFG_POLYNOMIAL: regs_model.polynomial = val;
      CFG_INITIAL:    regs_model.initial_value = val;
      CFG_WORDS:      regs_model.frame_len = val[3:0];
      default: ;
    endcase
  endtask

  // Offer one byte, hold it until taken, then record what it should produce.
  task automatic push_byte(input logic [7:0] b, input logic s, input bit typed,
                           input cwd_result_t want);
    int          gap;
    cwd_result_t got;
    bit          has;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    frame_start <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    has = absorb_byte(b, s, got);
    if (has) begin
      pending_words.push_back(typed ? want : got);
    end
    sent++;
    if (sent % 40 == 0) begin
      calm = ($urandom_range(0, 3) == 0);
    end
  endtask

  task automatic send_word(input logic [7:0] hi, input logic [7:0] lo, input bit good_crc,
                           input logic s);
    logic [7:0] crc;
    crc = crc8_feed(crc8_feed(regs_model.initial_value, hi, regs_model.polynomial),
                    lo, regs_model.polynomial);
    if (!good_crc) begin
      crc ^= 8'($urandom_range(1, 255));
    end
    push_byte(hi, s, 1'b0, '0);
    push_byte(lo, 1'b0, 1'b0, '0);
    push_byte(crc, 1'b0, 1'b0, '0);
  endtask

  task automatic shuffle_regs();
    logic [7:0] pick [4];
    logic [3:0] len;
    pick = '{8'h00, 8'hFF, 8'h31, 8'h07};
    put_reg(CFG_POLYNOMIAL, ($urandom_range(0, 1) == 0) ? pick[$urandom_range(0, 3)]
                                                          : 8'($urandom));
    put_reg(CFG_INITIAL, ($urandom_range(0, 2) == 0) ? pick[$urandom_range(0, 1)]
                                                     : 8'($urandom));
    case ($urandom_range(0, 5))
      0:       len = 4'd0;
      1:       len = 4'd1;
      2:       len = 4'd8;
      3:       len = 4'd15;
      default: len = 4'($urandom_range(1, 8));
    endcase
    put_reg(CFG_WORDS, {4'($urandom), len});
    if ($urandom_range(0, 3) == 0) begin
      put_reg(CFG_SPARE, 8'($urandom));
    end
  endtask

  always @(posedge clk) begin
    cwd_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_words.size() == 0) begin
        $error("word %h arrived with none expected", word_value);
        fails++;
      end else begin
        want = pending_words.pop_front();
        if (word_value !== want.word_value) begin
          $error("word_value: expected %h, got %h", want.word_value, word_value);
          fails++;
        end
        if (word_ok !== want.word_ok) begin
          $error("word_ok: expected %b, got %b", want.word_ok, word_ok);
          fails++;
        end
        if (frame_ok !== want.frame_ok) begin
          $error("frame_ok: expected %b, got %b", want.frame_ok, frame_ok);
          fails++;
        end
        if (word_index !== want.word_index) begin
          $error("word_index: expected %0d, got %0d", want.word_index, word_index);
          fails++;
        end
        if (last_word !== want.last_word) begin
          $error("last_word: expected %b, got %b", want.last_word, last_word);
          fails++;
        end
      end
    end
    if (rst || calm) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 99) < 20) begin
      stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                               : $urandom_range(0, 2);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  initial begin
    plan_row_t plan[$];
    int        quota;
    int        r;
    logic      start;
    reset_model();
    // Default settings: the checksum of 0xBEEF is 0x92.
    plan.push_back(row_byte(8'hBE, 1'b1));
    plan.push_back(row_byte(8'hEF, 1'b0));
    plan.push_back(row_word(8'h92, 1'b0, 16'hBEEF, 1'b1, 1'b1, 3'd0, 1'b0));
    plan.push_back(row_byte(8'hBE, 1'b0));
    plan.push_back(row_byte(8'hEF, 1'b0));
    plan.push_back(row_word(8'h93, 1'b0, 16'hBEEF, 1'b0, 1'b0, 3'd1, 1'b0));
    plan.push_back(row_byte(8'hBE, 1'b0));
    plan.push_back(row_byte(8'hEF, 1'b0));
    plan.push_back(row_word(8'h92, 1'b0, 16'hBEEF, 1'b1, 1'b0, 3'd2, 1'b1));
    // Frame start drops the open word.
    plan.push_back(row_byte(8'hFF, 1'b0));
    plan.push_back(row_byte(8'hFF, 1'b1));
    plan.push_back(row_byte(8'hFF, 1'b0));
    plan.push_back(row_byte(8'h5A, 1'b0));
    // Zero polynomial makes every checksum zero; zero length acts as one word.
    plan.push_back(row_cfg(CFG_POLYNOMIAL, 8'h00));
    plan.push_back(row_cfg(CFG_WORDS, 8'h00));
    plan.push_back(row_byte(8'h00, 1'b1));
    plan.push_back(row_byte(8'h00, 1'b0));
    plan.push_back(row_word(8'h00, 1'b0, 16'h0000, 1'b1, 1'b1, 3'd0, 1'b1));
    plan.push_back(row_byte(8'hFF, 1'b0));
    plan.push_back(row_byte(8'hFF, 1'b0));
    plan.push_back(row_word(8'h00, 1'b0, 16'hFFFF, 1'b1, 1'b1, 3'd0, 1'b1));
    plan.push_back(row_byte(8'hFF, 1'b0));
    plan.push_back(row_byte(8'hFF, 1'b0));
    plan.push_back(row_word(8'hFF, 1'b0, 16'hFFFF, 1'b0, 1'b0, 3'd0, 1'b1));
    // Length 15 clamps to 8; spare index must not land anywhere.
    plan.push_back(row_cfg(CFG_POLYNOMIAL, 8'hFF));
    plan.push_back(row_cfg(CFG_INITIAL, 8'h00));
    plan.push_back(row_cfg(CFG_WORDS, 8'hFF));
    plan.push_back(row_cfg(CFG_SPARE, 8'h55));
    // Initial value changes between the high byte and the rest of the word.
    plan.push_back(row_byte(8'h12, 1'b1));
    plan.push_back(row_cfg(CFG_INITIAL, 8'hA5));
    plan.push_back(row_byte(8'h34, 1'b0));
    plan.push_back(row_byte(8'h00, 1'b0));

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      case (plan[i].kind)
        ROW_CFG:  put_reg(plan[i].reg_index, plan[i].value);
        ROW_WORD: push_byte(plan[i].value, plan[i].start, 1'b1, plan[i].want);
        default:  push_byte(plan[i].value, plan[i].start, 1'b0, '0);
      endcase
    end

    while (sent < TOTAL_ITEMS) begin
      shuffle_regs();
      quota = sent + $urandom_range(30, 80);
      while (sent < quota) begin
        r = $urandom_range(0, 99);
        if (r < 80) begin
          // resync if a broken word left the triplet misaligned
          start = (rx.phase != PH_HIGH) || (rx.word_no == 3'd0 && $urandom_range(0, 1) == 1)
                  || ($urandom_range(0, 19) == 0);
          send_word(rand_byte(), rand_byte(), $urandom_range(0, 9) != 0, start);
        end else if (r < 90) begin
          push_byte(rand_byte(), 1'($urandom_range(0, 1)), 1'b0, '0);
          if ($urandom_range(0, 1) == 1) begin
            push_byte(rand_byte(), 1'b0, 1'b0, '0);
          end
        end else begin
          push_byte(rand_byte(), $urandom_range(0, 3) == 0, 1'b0, '0);
        end
      end
      // leave a word open across the next register writes now and then
      if ($urandom_range(0, 3) == 0) begin
        push_byte(rand_byte(), 1'($urandom_range(0, 1)), 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (2 * SETTLE_CYCLES) @(posedge clk);
    if (fails == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// File: files.f
+incdir+sv
sv/cwd_pkg.sv
sv/cwd_cfg_regs.sv
sv/cwd_assembler.sv
sv/cwd_out_reg.sv
sv/crc8_checked_word_deframer.sv
verif/tb_crc8_checked_word_deframer.sv
